/* src/tpvp_pkg.sv */
// Shared types and constants for the trapezoid peak velocity planner.
// Used by every module in src; depends on nothing.
package tpvp_pkg;

  // field widths
  localparam int unsigned SpanW  = 32;
  localparam int unsigned RateW  = 31;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IdxW   = 2;

  // serial unit sizes
  localparam int unsigned MulXW  = 64;
  localparam int unsigned MulYW  = 33;
  localparam int unsigned MulPW  = MulXW + MulYW;
  localparam int unsigned DivNW  = 96;
  localparam int unsigned DivDW  = 32;
  localparam int unsigned SqrtNW = 62;
  localparam int unsigned SqrtRW = SqrtNW / 2;
  localparam int unsigned RadW   = 98;

  // register indexes
  localparam logic [IdxW-1:0] REG_LIN_ACC = 2'd0;
  localparam logic [IdxW-1:0] REG_LIN_DEC = 2'd1;
  localparam logic [IdxW-1:0] REG_ANG_ACC = 2'd2;
  localparam logic [IdxW-1:0] REG_ANG_DEC = 2'd3;

  localparam logic [RateW-1:0] RATE_RESET = 31'd65536;

  // status codes
  localparam logic [StatW-1:0] ST_CRUISE  = 2'd0;
  localparam logic [StatW-1:0] ST_REDUCED = 2'd1;
  localparam logic [StatW-1:0] ST_HELD    = 2'd2;
  localparam logic [StatW-1:0] ST_CLAMP   = 2'd3;

  localparam logic MODE_LINEAR = 1'b0;

  typedef struct packed {
    logic                    mode;
    logic signed [SpanW-1:0] remaining_span;
    logic signed [SpanW-1:0] present_speed;
    logic signed [SpanW-1:0] cruise_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [SpanW-1:0] target_speed;
    logic [StatW-1:0]        status;
  } out_item_t;

endpackage

/* src/tpvp_mul.sv */
// Serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on tpvp_pkg.
module tpvp_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tpvp_pkg::MulXW-1:0]     x,
  input  logic [tpvp_pkg::MulYW-1:0]     y,
  output logic                           done,
  output logic [tpvp_pkg::MulPW-1:0]     product
);

  logic [tpvp_pkg::MulXW-1:0] x_r;
  logic [tpvp_pkg::MulYW-1:0] y_r;
  logic [tpvp_pkg::MulPW-1:0] acc_r, acc_nxt;
  logic [5:0]                 cnt_r;
  logic                       done_r;

  // shift accumulator, add multiplicand on a set bit
  always_comb begin
    acc_nxt = {acc_r[tpvp_pkg::MulPW-2:0], 1'b0};
    if (y_r[tpvp_pkg::MulYW-1]) begin
      acc_nxt = acc_nxt + {{tpvp_pkg::MulYW{1'b0}}, x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 6'd1);
      if (start) begin
        cnt_r <= 6'(tpvp_pkg::MulYW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      y_r   <= {y_r[tpvp_pkg::MulYW-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

/* src/tpvp_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on tpvp_pkg.
module tpvp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tpvp_pkg::DivNW-1:0]  num,
  input  logic [tpvp_pkg::DivDW-1:0]  den,
  output logic                        done,
  output logic [tpvp_pkg::DivNW-1:0]  quot
);

  logic [tpvp_pkg::DivNW-1:0] num_r;
  logic [tpvp_pkg::DivDW-1:0] den_r;
  logic [tpvp_pkg::DivDW-1:0] rem_r;
  logic [tpvp_pkg::DivDW:0]   rem_sh, rem_sub;
  logic                       qbit;
  logic [6:0]                 cnt_r;
  logic                       done_r;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, num_r[tpvp_pkg::DivNW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    qbit    = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 7'd1);
      if (start) begin
        cnt_r <= 7'(tpvp_pkg::DivNW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  // quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[tpvp_pkg::DivNW-2:0], qbit};
      rem_r <= qbit ? rem_sub[tpvp_pkg::DivDW-1:0] : rem_sh[tpvp_pkg::DivDW-1:0];
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

/* src/tpvp_sqrt.sv */
// Serial integer square root, two radicand bits per cycle.
// Depends on tpvp_pkg.
module tpvp_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tpvp_pkg::SqrtNW-1:0]  src,
  output logic                         done,
  output logic [tpvp_pkg::SqrtRW-1:0]  root
);

  logic [tpvp_pkg::SqrtNW-1:0] src_r;
  logic [tpvp_pkg::SqrtRW-1:0] root_r;
  logic [31:0]                 rem_r;
  logic [33:0]                 rem_sh, trial, rem_sub;
  logic                        rbit;
  logic [4:0]                  cnt_r;
  logic                        done_r;

  // try appending a one to the root
  always_comb begin
    rem_sh  = {rem_r, src_r[tpvp_pkg::SqrtNW-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_sub = rem_sh - trial;
    rbit    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 5'd1);
      if (start) begin
        cnt_r <= 5'(tpvp_pkg::SqrtRW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r  <= src;
      root_r <= '0;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      src_r  <= {src_r[tpvp_pkg::SqrtNW-3:0], 2'b00};
      root_r <= {root_r[tpvp_pkg::SqrtRW-2:0], rbit};
      rem_r  <= rbit ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* src/trapezoid_peak_velocity_planner.sv */
// Top level of the trapezoid peak velocity planner: sequencer and result register.
// Depends on tpvp_pkg, tpvp_mul, tpvp_div and tpvp_sqrt.
//
// Usage: an item (mode, remaining_span, present_speed, cruise_speed) transfers on
// in_valid high with in_stall low; one result (target_speed, status) transfers on
// out_valid high with out_stall low. Rate registers are written through cfg_*
// (index 0..3: linear accel, linear decel, angular accel, angular decel), which is
// always ready; write only while the block is idle.
// A linear item with no span left skips the arithmetic and reports the held target.
// Any other item runs six serial multiplies on one shared shift-add unit, which
// settle a cruise or clamped answer. A reduced peak adds a serial divide and a
// serial root; the root is skipped when the quotient alone saturates the peak.
// One item is in work at a time; in_stall is high from the transfer until the
// result is loaded into the output register. The next item can transfer while
// that result still waits in the output register.
// A stalled result holds in the output register; the sequencer waits for it to
// drain before loading the next. Reset (rst_n low, synchronous) clears the held
// linear target, sets all rates to 1.0 and empties the output register.
module trapezoid_peak_velocity_planner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tpvp_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tpvp_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpvp_pkg::IdxW-1:0]         cfg_index,
  input  logic [tpvp_pkg::RateW-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_OUT
  } state_t;

  // multiply sequence
  localparam logic [2:0] OP_VSQ   = 3'd0;
  localparam logic [2:0] OP_CSQ   = 3'd1;
  localparam logic [2:0] OP_AD    = 3'd2;
  localparam logic [2:0] OP_AVAIL = 3'd3;
  localparam logic [2:0] OP_VTERM = 3'd4;
  localparam logic [2:0] OP_CTERM = 3'd5;

  localparam int unsigned W  = tpvp_pkg::SpanW;
  localparam int unsigned RW = tpvp_pkg::RateW;
  localparam int unsigned RD = tpvp_pkg::RadW;

  state_t state_r;
  logic [2:0] op_r;

  logic [RW-1:0] lin_acc_r, lin_dec_r, ang_acc_r, ang_dec_r;
  logic [W-1:0]  held_r;

  // latched item
  logic          mode_r, s_neg_r;
  logic [W-1:0]  s_mag_r, v_mag_r, c_mag_r, cap_r;
  logic [RW-1:0] a_r, d_r;
  logic [W-1:0]  den_r;

  // intermediates
  logic [63:0]   v2_r, c2_r;
  logic [61:0]   ad_r;
  logic [RD-1:0] rad_r;

  logic [W-1:0]              res_target_r;
  logic [tpvp_pkg::StatW-1:0] res_status_r;

  tpvp_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                out_load;

  // serial unit hookup
  logic                          mul_start, mul_done;
  logic [tpvp_pkg::MulXW-1:0]    mul_x;
  logic [tpvp_pkg::MulYW-1:0]    mul_y;
  logic [tpvp_pkg::MulPW-1:0]    mul_p;
  logic                          div_start, div_done;
  logic [tpvp_pkg::DivNW-1:0]    div_q;
  logic                          sqrt_start, sqrt_done;
  logic [tpvp_pkg::SqrtRW-1:0]   sqrt_root;

  // input decode
  logic          in_xfer, guard;
  logic [W-1:0]  s_in, v_in, c_in, s_mag_in, v_mag_in, c_mag_in;
  logic [RW-1:0] a_sel, d_sel, a_in, d_in;
  logic [RD-1:0] avail_mag, avail_in, rad_sum, cterm, margin;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    s_in     = in_item.remaining_span;
    v_in     = in_item.present_speed;
    c_in     = in_item.cruise_speed;
    s_mag_in = s_in[W-1] ? (~s_in + 32'd1) : s_in;
    v_mag_in = v_in[W-1] ? (~v_in + 32'd1) : v_in;
    c_mag_in = c_in[W-1] ? (~c_in + 32'd1) : c_in;
    a_sel    = in_item.mode ? ang_acc_r : lin_acc_r;
    d_sel    = in_item.mode ? ang_dec_r : lin_dec_r;
    // a zero rate acts as the smallest legal rate
    a_in     = (a_sel == '0) ? 31'd1 : a_sel;
    d_in     = (d_sel == '0) ? 31'd1 : d_sel;
    guard    = (in_item.mode == tpvp_pkg::MODE_LINEAR) && (s_in[W-1] || s_in == '0);
  end

  // multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (op_r)
      OP_VSQ: begin
        mul_x = {32'd0, v_mag_r};
        mul_y = {1'b0, v_mag_r};
      end
      OP_CSQ: begin
        mul_x = {32'd0, c_mag_r};
        mul_y = {1'b0, c_mag_r};
      end
      OP_AD: begin
        mul_x = {33'd0, a_r};
        mul_y = {2'b00, d_r};
      end
      OP_AVAIL: begin
        mul_x = {2'b00, ad_r};
        mul_y = {s_mag_r, 1'b0};
      end
      OP_VTERM: begin
        mul_x = v2_r;
        mul_y = {2'b00, d_r};
      end
      OP_CTERM: begin
        mul_x = c2_r;
        mul_y = {1'b0, den_r};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // wide sums on the product
  always_comb begin
    avail_mag = {3'd0, mul_p[94:0]};
    avail_in  = s_neg_r ? (~avail_mag + 98'd1) : avail_mag;
    rad_sum   = rad_r + {3'd0, mul_p[94:0]};
    cterm     = {2'd0, mul_p[95:0]};
    margin    = rad_r - cterm;
  end

  assign mul_start  = (state_r == S_MUL_GO);
  assign div_start  = (state_r == S_DIV_GO);
  assign sqrt_start = (state_r == S_SQRT_GO);

  tpvp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .done    (mul_done),
    .product (mul_p)
  );

  tpvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rad_r[tpvp_pkg::DivNW-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  tpvp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .src   (div_q[tpvp_pkg::SqrtNW-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_acc_r <= tpvp_pkg::RATE_RESET;
      lin_dec_r <= tpvp_pkg::RATE_RESET;
      ang_acc_r <= tpvp_pkg::RATE_RESET;
      ang_dec_r <= tpvp_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpvp_pkg::REG_LIN_ACC: lin_acc_r <= cfg_data;
        tpvp_pkg::REG_LIN_DEC: lin_dec_r <= cfg_data;
        tpvp_pkg::REG_ANG_ACC: ang_acc_r <= cfg_data;
        tpvp_pkg::REG_ANG_DEC: ang_dec_r <= cfg_data;
        default: lin_acc_r <= lin_acc_r;
      endcase
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      op_r        <= OP_VSQ;
    end else begin
      // output register: load a new result or drain the old one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mode_r  <= in_item.mode;
            s_neg_r <= s_in[W-1];
            s_mag_r <= s_mag_in;
            v_mag_r <= v_mag_in;
            c_mag_r <= c_mag_in;
            cap_r   <= c_in;
            a_r     <= a_in;
            d_r     <= d_in;
            den_r   <= {1'b0, a_in} + {1'b0, d_in};
            op_r    <= OP_VSQ;
            if (guard) begin
              res_target_r <= held_r;
              res_status_r <= tpvp_pkg::ST_HELD;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_MUL_GO;
            end
          end
        end
        S_MUL_GO: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            op_r <= op_r + 3'd1;
            case (op_r)
              OP_VSQ: begin
                v2_r    <= mul_p[63:0];
                state_r <= S_MUL_GO;
              end
              OP_CSQ: begin
                c2_r    <= mul_p[63:0];
                state_r <= S_MUL_GO;
              end
              OP_AD: begin
                ad_r    <= mul_p[61:0];
                state_r <= S_MUL_GO;
              end
              OP_AVAIL: begin
                rad_r   <= avail_in;
                state_r <= S_MUL_GO;
              end
              OP_VTERM: begin
                rad_r   <= rad_sum;
                state_r <= S_MUL_GO;
              end
              OP_CTERM: begin
                if (!margin[RD-1] && margin != '0) begin
                  res_target_r <= cap_r;
                  res_status_r <= tpvp_pkg::ST_CRUISE;
                  state_r      <= S_OUT;
                end else if (rad_r[RD-1]) begin
                  res_target_r <= '0;
                  res_status_r <= tpvp_pkg::ST_CLAMP;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_DIV_GO;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            // quotient of 2^62 or more gives a root past the signed range
            if (div_q[tpvp_pkg::DivNW-1:tpvp_pkg::SqrtNW] != '0) begin
              res_target_r <= 32'h7FFF_FFFF;
              res_status_r <= tpvp_pkg::ST_REDUCED;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_SQRT_GO;
            end
          end
        end
        S_SQRT_GO: state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            res_target_r <= {1'b0, sqrt_root};
            res_status_r <= tpvp_pkg::ST_REDUCED;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.target_speed <= res_target_r;
            out_r.status       <= res_status_r;
            if (mode_r == tpvp_pkg::MODE_LINEAR && res_status_r != tpvp_pkg::ST_HELD) begin
              held_r <= res_target_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  // one item in work at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while an item was in work");

  // multiplier finishes only while the sequencer waits for it
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL_WAIT))
    else $error("multiplier done outside its wait state");

  // a clamped radicand always reports zero speed
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == tpvp_pkg::ST_CLAMP) |-> (out_r.target_speed == '0))
    else $error("clamped status with nonzero speed");
`endif

endmodule
